>>> rtl/cvf_pkg.sv
// Package for the 3x3 image convolution filter.
// Holds widths, register and mode codes, the divide-by-nine reciprocal and shared types.
// No dependencies.
package cvf_pkg;

  localparam int PIX_W       = 16;
  localparam int DIM_W       = 11;
  localparam int MODE_W      = 2;
  localparam int MAXV_W      = 16;
  localparam int SUM_W       = 20;  // sum of nine pixels
  localparam int EDGE_W      = 18;  // sum of four pixels
  localparam int GAIN_W      = 19;  // five times the centre
  localparam int DIFF_W      = 20;  // signed gain minus edges
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int OFIFO_DEPTH = 8;
  localparam int CFG_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  // ceil(2^24 / 9): exact floor division for any nine-pixel sum.
  localparam logic [RECIP_W-1:0] RECIP_9 = 21'd1864136;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE    = 2'd3;

  localparam logic [MODE_W-1:0] MODE_BLUR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LAPLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd2;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [MAXV_W-1:0] RST_MAX_VALUE    = 16'd255;

  // Per-item decisions taken at acceptance.
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
    logic flush;
  } cvf_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } cvf_res_t;

endpackage

>>> rtl/cvf_if.sv
// Stream interfaces for the 3x3 image convolution filter: pixel input and result output.
// Depends on cvf_pkg.
interface cvf_pix_if import cvf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface cvf_res_if import cvf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

>>> rtl/cvf_ctrl.sv
// Position counters of the 3x3 filter: input column and row, result column and row.
// Decides per accepted beat whether it pushes, emits, is interior and ends the frame.
// Depends on cvf_pkg.
module cvf_ctrl import cvf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [DIM_W-1:0]             image_width,
  input  logic [DIM_W-1:0]             image_height,
  input  logic                         accept,
  input  logic                         action,
  output logic                         push,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output cvf_item_t                    item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int WD = (WW > DIM_W) ? WW : DIM_W;
  localparam int HD = (RW > DIM_W) ? RW : DIM_W;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] output_column;
  logic [RW-1:0] output_row;

  logic [WD-1:0] w_ext, w_sat;
  logic [HD-1:0] h_ext, h_sat;
  logic [CW:0]   w_cmp, col_plus, ocol_plus;
  logic [RW:0]   h_cmp, row_plus, orow_plus;
  logic          tail;

  // Zero dimensions count as one, oversized ones saturate to the maximum.
  always_comb begin
    w_ext = WD'(image_width);
    h_ext = HD'(image_height);
    if (w_ext == '0) begin
      w_sat = WD'(1);
    end else if (w_ext > WD'(MAX_WIDTH)) begin
      w_sat = WD'(MAX_WIDTH);
    end else begin
      w_sat = w_ext;
    end
    if (h_ext == '0) begin
      h_sat = HD'(1);
    end else if (h_ext > HD'(MAX_HEIGHT)) begin
      h_sat = HD'(MAX_HEIGHT);
    end else begin
      h_sat = h_ext;
    end
    w_cmp = (CW+1)'(w_sat[WW-1:0]);
    h_cmp = (RW+1)'(h_sat);
  end

  assign col_plus  = {1'b0, column_count} + (CW+1)'(1);
  assign ocol_plus = {1'b0, output_column} + (CW+1)'(1);
  assign row_plus  = {1'b0, row_count} + (RW+1)'(1);
  assign orow_plus = {1'b0, output_row} + (RW+1)'(1);

  assign tail = {1'b0, row_count} >= h_cmp;
  assign push = tail || (action == ACT_PIXEL);
  assign col  = column_count;

  always_comb begin
    item.flush    = tail;
    item.emit     = (row_count >= RW'(2)) || (row_count == RW'(1) && column_count != '0);
    item.interior = (output_row != '0) && (orow_plus < h_cmp) &&
                    (output_column != '0) && (ocol_plus < w_cmp);
    item.last     = (orow_plus >= h_cmp) && (ocol_plus >= w_cmp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      output_column <= '0;
      output_row    <= '0;
    end else if (accept && push) begin
      if (item.emit && item.last) begin
        column_count  <= '0;
        row_count     <= '0;
        output_column <= '0;
        output_row    <= '0;
      end else begin
        if (col_plus >= w_cmp) begin
          column_count <= '0;
          row_count    <= row_plus[RW-1:0];
        end else begin
          column_count <= col_plus[CW-1:0];
        end
        if (item.emit) begin
          if (ocol_plus >= w_cmp) begin
            output_column <= '0;
            output_row    <= orow_plus[RW-1:0];
          end else begin
            output_column <= ocol_plus[CW-1:0];
          end
        end
      end
    end
  end

endmodule

>>> rtl/cvf_line_mem.sv
// Line store of the 3x3 filter: one synchronous memory holding the two previous lines.
// Read-modify-write per column with forwarding, and a zeroing sweep after reset.
// Depends on cvf_pkg.
module cvf_line_mem import cvf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic [PIX_W-1:0]             rd_px,
  output logic                         clearing,
  output logic                         col_valid,
  output logic [PIX_W-1:0]             col_upper,
  output logic [PIX_W-1:0]             col_middle,
  output logic [PIX_W-1:0]             col_px
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Each word holds {upper line, middle line} of one column.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata;
  logic [CW-1:0]      addr_q;
  logic [PIX_W-1:0]   px_q;
  logic [CW-1:0]      clr_addr;
  logic [2*PIX_W-1:0] wb_word;
  logic               wr_en;
  logic [CW-1:0]      wr_addr;
  logic [2*PIX_W-1:0] wr_word;

  // The middle line moves up, the new pixel becomes the middle line.
  assign wb_word = {rdata[PIX_W-1:0], px_q};
  assign wr_en   = clearing || col_valid;
  assign wr_addr = clearing ? clr_addr : addr_q;
  assign wr_word = clearing ? '0 : wb_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      col_valid <= 1'b0;
    end else begin
      col_valid <= rd_en;
      if (clearing) begin
        if (clr_addr == CW'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      addr_q <= rd_addr;
      px_q   <= rd_px;
      // A narrow image revisits the column being written back this cycle.
      if (col_valid && addr_q == rd_addr) begin
        rdata <= wb_word;
      end else begin
        rdata <= mem[rd_addr];
      end
    end
  end

  assign col_upper  = rdata[2*PIX_W-1:PIX_W];
  assign col_middle = rdata[PIX_W-1:0];
  assign col_px     = px_q;

endmodule

>>> rtl/cvf_kernel.sv
// Window and arithmetic of the 3x3 filter: nine-pixel window, box blur by reciprocal
// multiply, Laplacian and sharpening with clamping. Three register stages.
// Depends on cvf_pkg.
module cvf_kernel import cvf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take_item,
  input  cvf_item_t         item_in,
  input  logic              col_valid,
  input  logic [PIX_W-1:0]  col_upper,
  input  logic [PIX_W-1:0]  col_middle,
  input  logic [PIX_W-1:0]  col_px,
  input  logic [MODE_W-1:0] filter_mode,
  input  logic [MAXV_W-1:0] max_value,
  output logic              res_valid,
  output cvf_res_t          res
);

  // win[col*3+row], column 0 oldest, row 0 top.
  logic [PIX_W-1:0]  win  [9];
  logic [PIX_W-1:0]  wn   [9];
  cvf_item_t         item_q;

  logic [SUM_W-1:0]  sum9;
  logic [EDGE_W-1:0] edges;

  logic              v2, interior2, last2;
  logic [SUM_W-1:0]  sum2;
  logic [EDGE_W-1:0] edges2;
  logic [PIX_W-1:0]  centre2;

  logic [PROD_W-1:0] prod;
  logic [GAIN_W-1:0] gain;
  logic [DIFF_W-1:0] diff;
  logic [PIX_W-1:0]  clamped;

  logic              v3, interior3, last3;
  logic [PIX_W-1:0]  quot3, clamp3, centre3;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      wn[i] = win[i+3];
    end
    wn[6] = col_upper;
    wn[7] = col_middle;
    wn[8] = col_px;
    sum9 = '0;
    for (int i = 0; i < 9; i++) begin
      sum9 = sum9 + SUM_W'(wn[i]);
    end
    edges = EDGE_W'(wn[1]) + EDGE_W'(wn[3]) + EDGE_W'(wn[5]) + EDGE_W'(wn[7]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (col_valid) begin
        for (int i = 0; i < 9; i++) begin
          win[i] <= wn[i];
        end
      end
      v2 <= col_valid && item_q.emit;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      item_q <= item_in;
    end
    sum2      <= sum9;
    edges2    <= edges;
    centre2   <= wn[4];
    interior2 <= item_q.interior;
    last2     <= item_q.last;
  end

  always_comb begin
    prod = PROD_W'(sum2) * PROD_W'(RECIP_9);
    if (filter_mode == MODE_SHARPEN) begin
      gain = GAIN_W'({centre2, 2'b00}) + GAIN_W'(centre2);
    end else begin
      gain = GAIN_W'({centre2, 2'b00});
    end
    diff = {1'b0, gain} - DIFF_W'(edges2);
    if (diff[DIFF_W-1]) begin
      clamped = '0;
    end else if (diff[GAIN_W-1:0] > GAIN_W'(max_value)) begin
      clamped = max_value;
    end else begin
      clamped = diff[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quot3     <= prod[RECIP_SHIFT +: PIX_W];
    clamp3    <= clamped;
    centre3   <= centre2;
    interior3 <= interior2;
    last3     <= last2;
  end

  always_comb begin
    res.last = last3;
    if (!interior3) begin
      res.pixel = centre3;
    end else begin
      case (filter_mode)
        MODE_BLUR:    res.pixel = quot3;
        MODE_LAPLACE: res.pixel = clamp3;
        MODE_SHARPEN: res.pixel = clamp3;
        default:      res.pixel = centre3;
      endcase
    end
  end

  assign res_valid = v3;

endmodule

>>> rtl/cvf_out_fifo.sv
// Result queue of the 3x3 filter with slot reservation at input acceptance,
// so results in flight always find room. Depends on cvf_pkg.
module cvf_out_fifo import cvf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     reserve,
  input  logic     wr_en,
  input  cvf_res_t wr_data,
  input  logic     rd_en,
  output cvf_res_t rd_data,
  output logic     not_empty,
  output logic     has_room
);

  localparam int PW = $clog2(OFIFO_DEPTH);
  localparam int NW = $clog2(OFIFO_DEPTH + 1);

  cvf_res_t      store [OFIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill, credits;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      credits <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill    <= fill + NW'(wr_en) - NW'(rd_en);
      credits <= credits + NW'(reserve) - NW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  assign rd_data   = store[rd_ptr];
  assign not_empty = fill != '0;
  assign has_room  = credits < NW'(OFIFO_DEPTH);

endmodule

>>> rtl/image_conv3x3_filter_top.sv
// 3x3 image convolution filter: one pixel beat per clock while the result queue has room;
// results follow the beat that causes them through three register stages, then the result
// queue, one line plus one pixel behind the input. The line store takes one read and one
// write-back per pixel. Synchronous reset returns the registers to their defaults and then
// zeroes the line store; no pixel beat is taken during that sweep.
module image_conv3x3_filter_top import cvf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  cvf_pix_if.sink               pixel_stream,
  cvf_res_if.source             result_stream
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [MODE_W-1:0]    filter_mode;
  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  logic [MAXV_W-1:0]    max_value;
  logic [REG_IDX_W-1:0] reg_idx;

  logic             accept, push, clearing, has_room, not_empty;
  logic [CW-1:0]    col;
  cvf_item_t        item;
  logic [PIX_W-1:0] px;
  logic             col_valid, res_valid, pop;
  logic [PIX_W-1:0] col_upper, col_middle, col_px;
  cvf_res_t         res, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_BLUR;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      max_value    <= RST_MAX_VALUE;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FILTER_MODE:  filter_mode  <= pwdata[MODE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_MAX_VALUE:    max_value    <= pwdata[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILTER_MODE:  prdata = APB_DATA_W'(filter_mode);
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      REG_MAX_VALUE:    prdata = APB_DATA_W'(max_value);
      default:          prdata = '0;
    endcase
  end

  assign pixel_stream.ready = !clearing && has_room;
  assign accept = pixel_stream.valid && pixel_stream.ready;
  // Flush beats feed a zero pixel into the bottom row of the window.
  assign px = item.flush ? '0 : pixel_stream.pixel_in;

  cvf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .accept       (accept),
    .action       (pixel_stream.action),
    .push         (push),
    .col          (col),
    .item         (item)
  );

  cvf_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept && push),
    .rd_addr    (col),
    .rd_px      (px),
    .clearing   (clearing),
    .col_valid  (col_valid),
    .col_upper  (col_upper),
    .col_middle (col_middle),
    .col_px     (col_px)
  );

  cvf_kernel u_kernel (
    .clk         (clk),
    .rst         (rst),
    .take_item   (accept && push),
    .item_in     (item),
    .col_valid   (col_valid),
    .col_upper   (col_upper),
    .col_middle  (col_middle),
    .col_px      (col_px),
    .filter_mode (filter_mode),
    .max_value   (max_value),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign pop = result_stream.valid && result_stream.ready;

  cvf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .reserve   (accept && push && item.emit),
    .wr_en     (res_valid),
    .wr_data   (res),
    .rd_en     (pop),
    .rd_data   (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  assign result_stream.valid         = not_empty;
  assign result_stream.pixel_out     = head.pixel;
  assign result_stream.last_of_frame = head.last;

endmodule

>>> rtl/cvf_checker.sv
// Port-level checks for the 3x3 image convolution filter, bound to the top level.
// Depends on cvf_pkg and image_conv3x3_filter_top.
module cvf_checker import cvf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] pixel_out,
  input logic             last_of_frame
);

  // The line store sweep after reset keeps the input closed.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("pixel input ready straight after reset");

  // A result only shows up behind an earlier accepted pixel beat.
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result beat appeared without a matching input beat");

  // A stalled result beat keeps its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_of_frame))
    else $error("stalled result beat changed");

endmodule

bind image_conv3x3_filter_top cvf_checker u_cvf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixel_stream.valid),
  .in_ready      (pixel_stream.ready),
  .out_valid     (result_stream.valid),
  .out_ready     (result_stream.ready),
  .pixel_out     (result_stream.pixel_out),
  .last_of_frame (result_stream.last_of_frame)
);

>>> tb/tb_image_conv3x3_filter_top.sv
// Self-checking testbench for the 3x3 image convolution filter: a directed frame and random frames
// of pixel beats are checked against a line-store and window predictor kept in a small scoreboard class.
// Depends on cvf_pkg, the stream interfaces in cvf_if.sv and image_conv3x3_filter_top.
`timescale 1ns / 100ps

module tb_image_conv3x3_filter_top;
  import cvf_pkg::*;

  localparam int MAX_COLS       = 1024;
  localparam int MAX_ROWS       = 1024;
  localparam int GAP_MAX        = 16;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1050;

  // The package names three modes; the fourth code passes every pixel through.
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd3;

  class conv3x3_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [MAXV_W-1:0] maxv;
    logic [PIX_W-1:0]  upper [MAX_COLS];
    logic [PIX_W-1:0]  middle [MAX_COLS];
    logic [PIX_W-1:0]  win [9];
    int                col_cnt;
    int                row_cnt;
    int                out_col;
    int                out_row;
    cvf_res_t          pending [$];
    int                errors;

    function new();
      mode   = MODE_BLUR;
      width  = RST_IMAGE_WIDTH;
      height = RST_IMAGE_HEIGHT;
      maxv   = RST_MAX_VALUE;
      foreach (upper[i]) begin
        upper[i]  = '0;
        middle[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      out_col = 0;
      out_row = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_FILTER_MODE:  mode   = value[MODE_W-1:0];
        REG_IMAGE_WIDTH:  width  = value[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height = value[DIM_W-1:0];
        REG_MAX_VALUE:    maxv   = value[MAXV_W-1:0];
        default: ;
      endcase
    endfunction

    // A zero dimension counts as one; anything above the store size saturates.
    function int eff_dim(int v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    // Window layout: three column vectors, oldest first, top row first within each.
    function logic [PIX_W-1:0] filter_window();
      int centre;
      int edges;
      int acc;
      centre = int'(win[4]);
      edges  = int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(win[7]);
      acc    = 0;
      case (mode)
        MODE_BLUR: begin
          foreach (win[i]) acc += int'(win[i]);
          return PIX_W'(acc / 9);
        end
        MODE_LAPLACE: acc = 4 * centre - edges;
        MODE_SHARPEN: acc = 5 * centre - edges;
        default: return win[4];
      endcase
      if (acc < 0) return '0;
      if (acc > int'(maxv)) return maxv;
      return PIX_W'(acc);
    endfunction

    function void note_beat(logic act, logic [PIX_W-1:0] pix);
      int               w;
      int               h;
      int               col;
      int               k;
      logic [PIX_W-1:0] px;
      bit               tail;
      bit               emit;
      bit               interior;
      bit               frame_end;
      cvf_res_t         res;
      w    = eff_dim(width, MAX_COLS);
      h    = eff_dim(height, MAX_ROWS);
      tail = row_cnt >= h;
      // A drain beat before the frame's last pixel changes nothing.
      if (!tail && act == ACT_DRAIN) return;
      px   = tail ? '0 : pix;
      col  = (col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt;
      emit = row_cnt >= 2 || (row_cnt == 1 && col_cnt >= 1);
      for (k = 0; k < 6; k++) win[k] = win[k+3];
      win[6]      = upper[col];
      win[7]      = middle[col];
      win[8]      = px;
      upper[col]  = middle[col];
      middle[col] = px;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (!emit) return;
      interior  = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
      frame_end = out_row + 1 >= h && out_col + 1 >= w;
      res.pixel = interior ? filter_window() : win[4];
      res.last  = frame_end;
      pending.push_back(res);
      if (frame_end) begin
        col_cnt = 0;
        row_cnt = 0;
        out_col = 0;
        out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pix, logic last);
      cvf_res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got pixel_out %0d last_of_frame %0b",
                 $time, pix, last);
        return;
      end
      want = pending.pop_front();
      if (pix !== want.pixel) begin
        errors++;
        $display("%0t: pixel_out expected %0d, got %0d", $time, want.pixel, pix);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_frame expected %0b, got %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cvf_pix_if pix_bus ();
  cvf_res_if res_bus ();

  conv3x3_scoreboard board = new();
  bit                in_burst;
  bit                out_burst;
  int                items_sent;

  image_conv3x3_filter_top #(
    .MAX_WIDTH  (MAX_COLS),
    .MAX_HEIGHT (MAX_ROWS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pixel_stream  (pix_bus),
    .result_stream (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: a random stall before each beat, none at all while out_burst is set.
  initial begin : result_sink
    int stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!(res_bus.valid === 1'b1 && res_bus.ready === 1'b1));
      board.check_pixel(res_bus.pixel_out, res_bus.last_of_frame);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) ||
          (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) || psel === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // valid stays high from one beat to the next when no gap is drawn.
  task automatic send_beat(input logic act, input logic [PIX_W-1:0] pix);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid    <= 1'b1;
    pix_bus.action   <= act;
    pix_bus.pixel_in <= pix;
    do @(posedge clk); while (pix_bus.ready !== 1'b1);
    board.note_beat(act, pix);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode_sel, input logic [DIM_W-1:0] w_reg,
                           input logic [DIM_W-1:0] h_reg, input logic [MAXV_W-1:0] maxv_reg);
    write_reg(REG_FILTER_MODE, APB_DATA_W'(mode_sel));
    write_reg(REG_IMAGE_WIDTH, APB_DATA_W'(w_reg));
    write_reg(REG_IMAGE_HEIGHT, APB_DATA_W'(h_reg));
    write_reg(REG_MAX_VALUE, APB_DATA_W'(maxv_reg));
  endtask

  // Waits for every expected result, then lets beats that cause none leave the pipeline.
  task automatic settle();
    pix_bus.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return PIX_W'($urandom_range(0, board.maxv));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int w, input int h);
    int i;
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    for (i = 0; i < w * h; i++) begin
      // An early drain beat is ignored by the block.
      if ($urandom_range(0, 39) == 0) send_beat(ACT_DRAIN, PIX_W'($urandom));
      send_beat(ACT_PIXEL, pick_pixel());
    end
    // The flush tail: a pixel beat here counts as a drain step.
    for (i = 0; i <= w; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_beat(ACT_PIXEL, PIX_W'($urandom));
      else
        send_beat(ACT_DRAIN, PIX_W'($urandom));
    end
    items_sent += w * h + w + 1;
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode_sel, input logic [DIM_W-1:0] w_reg,
                           input logic [DIM_W-1:0] h_reg, input logic [MAXV_W-1:0] maxv_reg,
                           input int frames);
    int w;
    int h;
    configure(mode_sel, w_reg, h_reg, maxv_reg);
    w = board.eff_dim(w_reg, MAX_COLS);
    h = board.eff_dim(h_reg, MAX_ROWS);
    repeat (frames) send_frame(w, h);
    settle();
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0]  grid [12];
    logic [MODE_W-1:0] mode_sel;
    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [MAXV_W-1:0] maxv_reg;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    pix_bus.valid    <= 1'b0;
    pix_bus.action   <= ACT_PIXEL;
    pix_bus.pixel_in <= '0;
    in_burst         = 1'b0;
    out_burst        = 1'b0;
    items_sent       = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed 4x3 sharpening frame: one interior pixel clamps to zero, the other to max_value.
    grid = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
             16'hFFFF, 16'd200,  16'hFFFF, 16'h0000,
             16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
    configure(MODE_SHARPEN, 11'd4, 11'd3, 16'd255);
    send_beat(ACT_DRAIN, '1);
    foreach (grid[i]) send_beat(ACT_PIXEL, grid[i]);
    send_beat(ACT_PIXEL, 16'h1234);
    repeat (4) send_beat(ACT_DRAIN, '0);
    settle();

    // Fixed corner settings, each with random frame content.
    run_phase(MODE_PASS, 11'd5, 11'd4, 16'd255, 1);
    run_phase(MODE_LAPLACE, 11'd0, 11'd0, 16'd255, 2);
    run_phase(MODE_LAPLACE, 11'd6, 11'd5, 16'd0, 1);
    run_phase(MODE_SHARPEN, 11'd4, 11'd1, 16'hFFFF, 1);
    run_phase(MODE_BLUR, 11'd1, 11'd6, 16'd255, 1);
    run_phase(MODE_BLUR, 11'd3, 11'd2, 16'd1, 1);

    while (items_sent < RANDOM_ITEMS) begin
      mode_sel = MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       w_reg = 11'd0;
        1:       w_reg = 11'd1;
        2:       w_reg = 11'd2;
        default: w_reg = DIM_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h_reg = 11'd0;
        1:       h_reg = 11'd1;
        2:       h_reg = 11'd2;
        default: h_reg = DIM_W'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 4))
        0:       maxv_reg = 16'd0;
        1:       maxv_reg = 16'hFFFF;
        2:       maxv_reg = 16'd1;
        default: maxv_reg = MAXV_W'($urandom_range(1, 65535));
      endcase
      run_phase(mode_sel, w_reg, h_reg, maxv_reg, $urandom_range(1, 3));
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
